>>> sv/circular_deque_core_macros.svh
// Assertion macros used by the checker module.
`ifndef CIRCULAR_DEQUE_CORE_MACROS_SVH
`define CIRCULAR_DEQUE_CORE_MACROS_SVH

// Implication that must hold in the same cycle.
`define CDQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque check failed");

// Implication that must hold in the following cycle.
`define CDQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

>>> sv/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int WordW = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } cdq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_e;

  typedef struct packed {
    cdq_op_e                  opcode;
    logic signed [WordW-1:0]  push_value;
  } cdq_in_t;

  typedef struct packed {
    logic signed [WordW-1:0]  pop_value;
    cdq_status_e              status;
  } cdq_out_t;

  typedef struct packed {
    logic              shr;
    logic              shl;
    logic              wr_back;
    logic              rd_load;
    logic              rd_shift;
    logic [WordW-1:0]  value;
  } cdq_ctrl_t;

endpackage

>>> sv/cdq_cell.sv
`timescale 1ns / 1ps

module cdq_cell import cdq_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 3
) (
  input  logic             clk_i,
  input  cdq_ctrl_t        ctrl_i,
  input  logic [CW-1:0]    count_i,
  input  logic [WordW-1:0] left_data_i,
  input  logic [WordW-1:0] right_data_i,
  input  logic [WordW-1:0] right_rd_i,
  output logic [WordW-1:0] data_o,
  output logic [WordW-1:0] rd_o
);

  logic [WordW-1:0] data_q, data_d;
  logic [WordW-1:0] rd_q, rd_d;

  always_comb begin
    data_d = data_q;
    rd_d   = rd_q;
    if (ctrl_i.shr) begin
      data_d = (IDX == 0) ? ctrl_i.value : left_data_i;
    end else if (ctrl_i.shl) begin
      data_d = right_data_i;
    end else if (ctrl_i.wr_back && (count_i == CW'(IDX))) begin
      data_d = ctrl_i.value;
    end
    if (ctrl_i.rd_load) begin
      rd_d = data_q;
    end else if (ctrl_i.rd_shift) begin
      rd_d = right_rd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

>>> sv/circular_deque_core.sv
// Push front, push back and pop front: result strobe in the cycle after start; one word per cycle
// unless busy. Pop back of a deque holding N words: the last word walks down the cell row while
// busy is high, then the result strobes; a pop back on an empty deque answers in the next cycle.
// Reset (asynchronous, active low) empties the deque and clears busy and the strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module circular_deque_core import cdq_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  cdq_in_t  item_i,
  output logic     done_o,
  output cdq_out_t result_o
);

  localparam int NCELL = DEPTH - 1;
  localparam int CW    = $clog2(DEPTH);

  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    walk_cnt_q, walk_cnt_d;
  logic             walk_q, walk_d;
  logic             done_q, done_d;
  cdq_out_t         res_q, res_d;
  cdq_ctrl_t        ctrl;
  logic             accept, full, empty;
  logic [WordW-1:0] data_w [NCELL];
  logic [WordW-1:0] rd_w   [NCELL];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cdq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .left_data_i  ((i == 0) ? '0 : data_w[(i == 0) ? 0 : i - 1]),
      .right_data_i ((i == NCELL - 1) ? '0 : data_w[(i == NCELL - 1) ? i : i + 1]),
      .right_rd_i   ((i == NCELL - 1) ? '0 : rd_w[(i == NCELL - 1) ? i : i + 1]),
      .data_o       (data_w[i]),
      .rd_o         (rd_w[i])
    );
  end

  assign accept = start && !busy;
  assign full   = (count_q == CW'(NCELL));
  assign empty  = (count_q == '0);

  always_comb begin
    ctrl          = '0;
    ctrl.value    = item_i.push_value;
    count_d       = count_q;
    walk_d        = walk_q;
    walk_cnt_d    = walk_cnt_q;
    done_d        = 1'b0;
    res_d         = res_q;
    if (walk_q) begin
      if (walk_cnt_q == '0) begin
        walk_d          = 1'b0;
        done_d          = 1'b1;
        res_d.pop_value = rd_w[0];
        res_d.status    = ST_OK;
      end else begin
        ctrl.rd_shift = 1'b1;
        walk_cnt_d    = walk_cnt_q - 1'b1;
      end
    end else if (accept) begin
      res_d.pop_value = '0;
      res_d.status    = ST_OK;
      done_d          = 1'b1;
      case (item_i.opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            ctrl.shr     = (item_i.opcode == OP_PUSH_FRONT);
            ctrl.wr_back = (item_i.opcode == OP_PUSH_BACK);
            count_d      = count_q + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res_d.pop_value = '1;
            res_d.status    = ST_EMPTY;
          end else begin
            ctrl.shl        = 1'b1;
            res_d.pop_value = data_w[0];
            count_d         = count_q - 1'b1;
          end
        end
        default: begin
          if (empty) begin
            res_d.pop_value = '1;
            res_d.status    = ST_EMPTY;
          end else begin
            ctrl.rd_load = 1'b1;
            count_d      = count_q - 1'b1;
            walk_d       = 1'b1;
            walk_cnt_d   = count_q - 1'b1;
            done_d       = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      walk_q     <= 1'b0;
      walk_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      count_q    <= count_d;
      walk_q     <= walk_d;
      walk_cnt_q <= walk_cnt_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy     = walk_q;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

>>> sv/cdq_checker.sv
`timescale 1ns / 1ps
`include "circular_deque_core_macros.svh"

module cdq_checker import cdq_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input cdq_in_t  item_i,
  input logic     done_o,
  input cdq_out_t result_o
);

  `CDQ_ASSERT_NXT(a_quick_word, start && !busy && (item_i.opcode != OP_POP_BACK), done_o)
  `CDQ_ASSERT_IMP(a_full_zero, done_o && (result_o.status == ST_FULL), result_o.pop_value == 0)
  `CDQ_ASSERT_IMP(a_empty_ones, done_o && (result_o.status == ST_EMPTY), result_o.pop_value == -1)
  `CDQ_ASSERT_IMP(a_busy_quiet, busy, !done_o)
  `CDQ_ASSERT_IMP(a_walk_done, $fell(busy), done_o)

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (.*);
